// ----- rtl/smie_pkg.sv -----
// ----------------------------------------------------------------------------
// smie_pkg
// Shared types and constants for the stack machine integer executor.
// ----------------------------------------------------------------------------
package smie_pkg;

    localparam int DATA_W   = 64;
    localparam int OP_W     = 8;
    localparam int STAT_W   = 3;
    localparam int DEPTH_W  = 9;
    localparam int PC_W     = 32;
    localparam int SEL_W    = 3;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 112;
    localparam int STACK_DEPTH_DEF = 256;

    // Opcodes
    localparam logic [OP_W-1:0] OP_NOP  = 8'd0;
    localparam logic [OP_W-1:0] OP_HALT = 8'd1;
    localparam logic [OP_W-1:0] OP_PUSH = 8'd2;
    localparam logic [OP_W-1:0] OP_POP  = 8'd3;
    localparam logic [OP_W-1:0] OP_UADD = 8'd4;
    localparam logic [OP_W-1:0] OP_SADD = 8'd9;
    localparam logic [OP_W-1:0] OP_SREM = 8'd13;

    // Arithmetic selectors
    localparam logic [SEL_W-1:0] SEL_ADD = 3'd0;
    localparam logic [SEL_W-1:0] SEL_SUB = 3'd1;
    localparam logic [SEL_W-1:0] SEL_MUL = 3'd2;
    localparam logic [SEL_W-1:0] SEL_DIV = 3'd3;
    localparam logic [SEL_W-1:0] SEL_REM = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_HALT_NOW  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;
    localparam logic [STAT_W-1:0] ST_DIVZERO   = 3'd5;
    localparam logic [STAT_W-1:0] ST_HALTED    = 3'd6;

    // Controller to datapath
    typedef struct packed {
        logic              load_in;   // capture the input transfer
        logic              commit;    // apply step and load result register
        logic              push;
        logic              pop;
        logic              alu_wr;    // replace two entries with the result
        logic              halt;
        logic              adv_pc;
        logic              md_start;
        logic [STAT_W-1:0] status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic stopped;
        logic op_nop;
        logic op_halt;
        logic op_push;
        logic op_pop;
        logic op_arith;
        logic op_md;      // mul, div or rem
        logic op_div;     // div or rem
        logic empty;
        logic lt2;
        logic full;
        logic b_zero;
        logic md_done;
        logic out_busy;
    } sts_t;

endpackage

// ----- rtl/smie_muldiv.sv -----
// ----------------------------------------------------------------------------
// smie_muldiv
// Shared radix-2 unit: 64-step shift-add multiply or restoring divide.
// ----------------------------------------------------------------------------
module smie_muldiv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic                        is_div,
    input  logic [smie_pkg::DATA_W-1:0] opa,
    input  logic [smie_pkg::DATA_W-1:0] opb,
    output logic                        done,
    output logic [smie_pkg::DATA_W-1:0] res_acc,   // product or remainder
    output logic [smie_pkg::DATA_W-1:0] res_q      // quotient
);
    import smie_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic [DATA_W:0]   acc_reg, acc_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              div_reg, div_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_sub;

    // One step per cycle
    always_comb begin
        acc_next  = acc_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        rem_sh    = {acc_reg[DATA_W-1:0], q_reg[DATA_W-1]};
        rem_sub   = rem_sh - {1'b0, d_reg};
        if (start) begin
            acc_next  = '0;
            q_next    = is_div ? opa : opb;
            d_next    = is_div ? opb : opa;
            cnt_next  = CNT_W'(DATA_W);
            div_next  = is_div;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (div_reg) begin
                if (!rem_sub[DATA_W]) begin
                    acc_next = rem_sub;
                    q_next   = {q_reg[DATA_W-2:0], 1'b1};
                end else begin
                    acc_next = rem_sh;
                    q_next   = {q_reg[DATA_W-2:0], 1'b0};
                end
            end else begin
                if (q_reg[0]) begin
                    acc_next = {1'b0, acc_reg[DATA_W-1:0] + d_reg};
                end
                d_next = {d_reg[DATA_W-2:0], 1'b0};
                q_next = {1'b0, q_reg[DATA_W-1:1]};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        div_reg <= div_next;
    end

    assign done    = done_reg;
    assign res_acc = acc_reg[DATA_W-1:0];
    assign res_q   = q_reg;

endmodule

// ----- rtl/smie_dp.sv -----
// ----------------------------------------------------------------------------
// smie_dp
// Datapath: stack memory, top-of-stack register, counters, ALU, result reg.
// ----------------------------------------------------------------------------
module smie_dp #(
    parameter int STACK_DEPTH = smie_pkg::STACK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  smie_pkg::cmd_t                cmd,
    output smie_pkg::sts_t                sts,
    input  logic [smie_pkg::OP_W-1:0]     in_opcode,
    input  logic [smie_pkg::DATA_W-1:0]   in_imm,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [smie_pkg::STAT_W-1:0]   out_status,
    output logic [smie_pkg::DATA_W-1:0]   out_top,
    output logic [smie_pkg::DEPTH_W-1:0]  out_depth,
    output logic [smie_pkg::PC_W-1:0]     out_pc,
    output logic                          out_halted
);
    import smie_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Entries below the top; the top itself lives in tos_reg
    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [DATA_W-1:0] tos_reg, tos_next;
    logic [DATA_W-1:0] rd_reg;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              stop_reg, stop_next;
    logic              ovalid_reg;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic              wr_en;

    logic              sgn;
    logic [SEL_W-1:0]  sel;
    logic              na, nb;
    logic [DATA_W-1:0] ma, mb;
    logic [DATA_W-1:0] md_acc, md_q;
    logic              md_done;
    logic [DATA_W-1:0] alu_res;

    // Opcode decode
    assign sgn = (op_reg >= OP_SADD);
    assign sel = sgn ? SEL_W'(op_reg - OP_SADD) : SEL_W'(op_reg - OP_UADD);

    assign sts.stopped  = stop_reg;
    assign sts.op_nop   = (op_reg == OP_NOP);
    assign sts.op_halt  = (op_reg == OP_HALT);
    assign sts.op_push  = (op_reg == OP_PUSH);
    assign sts.op_pop   = (op_reg == OP_POP);
    assign sts.op_arith = (op_reg >= OP_UADD) && (op_reg <= OP_SREM);
    assign sts.op_md    = (sel >= SEL_MUL);
    assign sts.op_div   = (sel >= SEL_DIV);
    assign sts.empty    = (cnt_reg == '0);
    assign sts.lt2      = (cnt_reg < CW'(2));
    assign sts.full     = (cnt_reg == CW'(STACK_DEPTH));
    assign sts.b_zero   = (tos_reg == '0);
    assign sts.md_done  = md_done;
    assign sts.out_busy = ovalid_reg && !out_ready;

    // Operand magnitudes for divide and remainder on the shared unit
    assign na = sgn && rd_reg[DATA_W-1];
    assign nb = sgn && tos_reg[DATA_W-1];
    assign ma = na ? (DATA_W'(0) - rd_reg) : rd_reg;
    assign mb = nb ? (DATA_W'(0) - tos_reg) : tos_reg;

    smie_muldiv u_md (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.md_start),
        .is_div  (sts.op_div),
        .opa     (sel == SEL_MUL ? rd_reg : ma),
        .opb     (sel == SEL_MUL ? tos_reg : mb),
        .done    (md_done),
        .res_acc (md_acc),
        .res_q   (md_q)
    );

    // Result select, sign fixup after divide
    always_comb begin
        case (sel)
            SEL_ADD: alu_res = rd_reg + tos_reg;
            SEL_SUB: alu_res = rd_reg - tos_reg;
            SEL_MUL: alu_res = md_acc;
            SEL_DIV: alu_res = (na != nb) ? (DATA_W'(0) - md_q) : md_q;
            default: alu_res = na ? (DATA_W'(0) - md_acc) : md_acc;
        endcase
    end

    // Next architectural state
    always_comb begin
        tos_next  = tos_reg;
        cnt_next  = cnt_reg;
        pc_next   = pc_reg;
        stop_next = stop_reg;
        if (cmd.commit) begin
            if (cmd.push) begin
                tos_next = imm_reg;
                cnt_next = cnt_reg + CW'(1);
            end
            if (cmd.pop) begin
                tos_next = rd_reg;
                cnt_next = cnt_reg - CW'(1);
            end
            if (cmd.alu_wr) begin
                tos_next = alu_res;
                cnt_next = cnt_reg - CW'(1);
            end
            if (cmd.halt) begin
                stop_next = 1'b1;
            end
            if (cmd.adv_pc) begin
                pc_next = pc_reg + (sts.op_push ? PC_W'(9) : PC_W'(1));
            end
        end
    end

    assign rd_addr = AW'(cnt_reg - CW'(2));
    assign wr_addr = AW'(cnt_reg - CW'(1));
    assign wr_en   = cmd.commit && cmd.push && !sts.empty;

    // Stack memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= tos_reg;
        end
        rd_reg <= mem[rd_addr];
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            pc_reg     <= '0;
            stop_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            pc_reg   <= pc_next;
            stop_reg <= stop_next;
            if (cmd.commit) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
        if (cmd.load_in) begin
            op_reg  <= in_opcode;
            imm_reg <= in_imm;
        end
        if (cmd.commit) begin
            out_status <= cmd.status;
            out_top    <= (cnt_next == '0) ? '0 : tos_next;
            out_depth  <= DEPTH_W'(cnt_next);
            out_pc     <= pc_next;
            out_halted <= stop_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

// ----- rtl/smie_ctrl.sv -----
// ----------------------------------------------------------------------------
// smie_ctrl
// Controller: sequences accept, execute, shared-unit wait and commit.
// ----------------------------------------------------------------------------
module smie_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  smie_pkg::sts_t sts,
    output smie_pkg::cmd_t cmd
);
    import smie_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.status = ST_OK;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    cmd.adv_pc = 1'b1;
                    state_next = S_IDLE;
                    if (sts.stopped) begin
                        cmd.adv_pc = 1'b0;
                        cmd.status = ST_HALTED;
                    end else if (sts.op_nop) begin
                        cmd.status = ST_OK;
                    end else if (sts.op_halt) begin
                        cmd.halt   = 1'b1;
                        cmd.status = ST_HALT_NOW;
                    end else if (sts.op_push) begin
                        cmd.push   = !sts.full;
                        cmd.status = sts.full ? ST_OVERFLOW : ST_OK;
                    end else if (sts.op_pop) begin
                        cmd.pop    = !sts.empty;
                        cmd.status = sts.empty ? ST_UNDERFLOW : ST_OK;
                    end else if (sts.op_arith) begin
                        if (sts.lt2) begin
                            cmd.status = ST_UNDERFLOW;
                        end else if (sts.op_div && sts.b_zero) begin
                            cmd.status = ST_DIVZERO;
                        end else if (sts.op_md) begin
                            // hand off to the shared unit, commit later
                            cmd.commit   = 1'b0;
                            cmd.adv_pc   = 1'b0;
                            cmd.md_start = 1'b1;
                            state_next   = S_WAIT;
                        end else begin
                            cmd.alu_wr = 1'b1;
                        end
                    end else begin
                        cmd.status = ST_UNKNOWN;
                    end
                end
            end
            S_WAIT: begin
                if (sts.md_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    cmd.adv_pc = 1'b1;
                    cmd.alu_wr = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/stack_machine_integer_executor.sv -----
// ----------------------------------------------------------------------------
// stack_machine_integer_executor
// Executes one decoded stack-machine instruction per input transfer.
//
//  channel  dir  tdata fields (low bit first)
//  s_axis   in   opcode[7:0], immediate[71:8]
//  m_axis   out  status[2:0], top_value[66:3], depth[75:67],
//                program_counter[107:76], halted[108], zero pad to 112
//
// One instruction at a time. Nop, halt, push, pop, add and sub commit from the
// execute state; mul, div and rem with valid operands first wait for the shared
// radix-2 multiply/divide unit (64 steps). Reset clears depth, program
// counter, halted flag and the result valid; stack memory is not cleared.
// A result held back by m_axis_tready stalls the commit of the next step.
// ----------------------------------------------------------------------------
module stack_machine_integer_executor #(
    parameter int STACK_DEPTH = smie_pkg::STACK_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [smie_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // opcode, immediate
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [smie_pkg::M_TDATA_W-1:0]   m_axis_tdata   // status, top, depth, pc, halted
);
    import smie_pkg::*;

    cmd_t                cmd;
    sts_t                sts;
    logic [STAT_W-1:0]   o_status;
    logic [DATA_W-1:0]   o_top;
    logic [DEPTH_W-1:0]  o_depth;
    logic [PC_W-1:0]     o_pc;
    logic                o_halted;

    smie_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    smie_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_opcode  (s_axis_tdata[OP_W-1:0]),
        .in_imm     (s_axis_tdata[OP_W+DATA_W-1:OP_W]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (o_status),
        .out_top    (o_top),
        .out_depth  (o_depth),
        .out_pc     (o_pc),
        .out_halted (o_halted)
    );

    assign m_axis_tdata = {3'b000, o_halted, o_pc, o_depth, o_top, o_status};

    // Only one instruction is in flight
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an instruction is in flight");

    // Halted flag is sticky
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && o_halted |=> o_halted)
        else $error("halted flag cleared");

    // Unit start clears its done flag before the wait state samples it
    a_md_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.md_start |=> !sts.md_done)
        else $error("multiply/divide done raised at start");

    // A commit needs a free result register
    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !sts.out_busy)
        else $error("commit while result still waiting");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stack_machine_integer_executor. Instructions go in
// on s_axis and results come back on m_axis, both with random idle gaps. A
// local model of the stack, depth, program counter and halted flag predicts
// every result, and each received result is compared field by field. The
// directed tests come first: edge cases, a fill to overflow and a drain.
// The random test follows, and the halt test runs last.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smie_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // opcode, immediate
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;       // status, top, depth, pc, halted

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

    // Declared from the highest tdata bits down
    typedef struct packed {
        logic               halted;
        logic [PC_W-1:0]    pc;
        logic [DEPTH_W-1:0] depth;
        logic [DATA_W-1:0]  top;
        logic [STAT_W-1:0]  status;
    } vm_result_t;

    // Machine state as the bench sees it
    logic [DATA_W-1:0]  vm_stack [STACK_DEPTH_DEF];
    int unsigned        vm_count;
    logic [PC_W-1:0]    vm_pc;
    logic               vm_halted;

    vm_result_t  pending_results[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    bit          no_idle;      // stretch with no gaps on either side

    stack_machine_integer_executor dut (.*);

    always #6 aclk = ~aclk;

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1;
            2: return '1;
            3: return MIN64;
            4: return MAX64;
            5: return 64'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Arithmetic unit: sel is add, sub, mul, div or rem; divisor nonzero
    function automatic logic [63:0] arith_result(logic [SEL_W-1:0] sel, bit sgn,
                                                 logic [63:0] a, logic [63:0] b);
        logic [63:0] ma, mb, q;
        bit          na, nb;
        na = sgn && a[63];
        nb = sgn && b[63];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        case (sel)
            SEL_ADD: return a + b;
            SEL_SUB: return a - b;
            SEL_MUL: return a * b;
            SEL_DIV: begin
                q = ma / mb;
                return (na != nb) ? -q : q;
            end
            default: begin
                q = ma % mb;
                return na ? -q : q;
            end
        endcase
    endfunction

    // Apply one accepted instruction to the bench state, queue its result
    task automatic execute_instr(logic [OP_W-1:0] op, logic [63:0] imm);
        vm_result_t       r;
        logic [SEL_W-1:0] sel;
        bit               sgn;
        r.status = ST_OK;
        if (vm_halted) begin
            r.status = ST_HALTED;
        end else if (op == OP_NOP) begin
            vm_pc += 1;
        end else if (op == OP_HALT) begin
            vm_halted = 1'b1;
            vm_pc += 1;
            r.status = ST_HALT_NOW;
        end else if (op == OP_PUSH) begin
            vm_pc += 9;
            if (vm_count >= STACK_DEPTH_DEF) begin
                r.status = ST_OVERFLOW;
            end else begin
                vm_stack[vm_count] = imm;
                vm_count++;
            end
        end else if (op == OP_POP) begin
            vm_pc += 1;
            if (vm_count == 0) r.status = ST_UNDERFLOW;
            else vm_count--;
        end else if (op >= OP_UADD && op <= OP_SREM) begin
            sgn = op >= OP_SADD;
            sel = SEL_W'(op - (sgn ? OP_SADD : OP_UADD));
            vm_pc += 1;
            if (vm_count < 2) begin
                r.status = ST_UNDERFLOW;
            end else if (sel >= SEL_DIV && vm_stack[vm_count-1] == 0) begin
                r.status = ST_DIVZERO;
            end else begin
                vm_stack[vm_count-2] = arith_result(sel, sgn, vm_stack[vm_count-2],
                                                    vm_stack[vm_count-1]);
                vm_count--;
            end
        end else begin
            vm_pc += 1;
            r.status = ST_UNKNOWN;
        end
        r.top    = vm_count != 0 ? vm_stack[vm_count-1] : '0;
        r.depth  = DEPTH_W'(vm_count);
        r.pc     = vm_pc;
        r.halted = vm_halted;
        pending_results.push_back(r);
    endtask

    // Send one instruction; returns once its transfer is accepted
    task automatic send_instr(logic [OP_W-1:0] op, logic [63:0] imm);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {imm, op};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        execute_instr(op, imm);
        items_sent++;
    endtask

    task automatic arith_op(logic [SEL_W-1:0] sel, bit sgn);
        send_instr((sgn ? OP_SADD : OP_UADD) + OP_W'(sel), {$urandom, $urandom});
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Result side: random back-pressure
    always @(negedge aclk) begin
        m_axis_tready <= no_idle ? 1'b1 : (pick_gap() == 0);
    end

    // Result checker
    always @(posedge aclk) begin
        vm_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = vm_result_t'(m_axis_tdata[108:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at result %0d: expected %p, got %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    // Edge cases on a small stack
    task automatic test_edge_cases();
        send_instr(OP_NOP, '1);
        send_instr(8'd14, '0);
        send_instr(8'd255, '1);
        send_instr(8'h80, 64'h5555_5555_5555_5555);
        send_instr(OP_POP, '0);            // pop on empty stack
        send_instr(OP_PUSH, '1);
        arith_op(SEL_ADD, 1'b0);           // one entry only
        send_instr(OP_PUSH, '0);
        arith_op(SEL_DIV, 1'b0);           // divide by zero
        arith_op(SEL_REM, 1'b1);
        arith_op(SEL_ADD, 1'b0);
        send_instr(OP_PUSH, MIN64);
        send_instr(OP_PUSH, '1);
        arith_op(SEL_DIV, 1'b1);           // minimum over minus one
        send_instr(OP_PUSH, MIN64);
        send_instr(OP_PUSH, '1);
        arith_op(SEL_REM, 1'b1);
        send_instr(OP_PUSH, -64'd7);
        send_instr(OP_PUSH, 64'd2);
        arith_op(SEL_DIV, 1'b1);           // truncation toward zero
        send_instr(OP_PUSH, MAX64);
        arith_op(SEL_MUL, 1'b1);
        arith_op(SEL_SUB, 1'b0);
        send_instr(OP_POP, '0);
        send_instr(OP_POP, '0);
    endtask

    // Fill the stack, push twice more, then empty it and pop once more
    task automatic test_full_stack();
        no_idle = 1'b1;
        while (vm_count < STACK_DEPTH_DEF) send_instr(OP_PUSH, pick_value());
        no_idle = 1'b0;
        send_instr(OP_PUSH, '1);
        send_instr(OP_PUSH, '0);
        while (vm_count > 0) send_instr(OP_POP, '0);
        send_instr(OP_POP, '0);
        wait_drained();
    endtask

    // Random programs with a shallow stack, some noise mixed in
    task automatic test_random_programs(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 75) no_idle = ~no_idle;
            if (i == count / 2) wait_drained();
            r = $urandom_range(0, 99);
            if (vm_count < 2 && r < 70 || vm_count < 24 && r < 30)
                send_instr(OP_PUSH, pick_value());
            else if (r < 80)
                send_instr(OP_UADD + OP_W'($urandom_range(0, 9)), {$urandom, $urandom});
            else if (r < 88)
                send_instr(OP_POP, {$urandom, $urandom});
            else if (r < 94)
                send_instr(OP_NOP, {$urandom, $urandom});
            else
                send_instr(OP_W'($urandom_range(14, 255)), {$urandom, $urandom});
        end
        no_idle = 1'b0;
    endtask

    // Halt stops everything that follows
    task automatic test_halt();
        send_instr(OP_PUSH, 64'd3);
        send_instr(OP_HALT, '1);
        send_instr(OP_PUSH, 64'd4);
        send_instr(OP_UADD, '0);
        send_instr(OP_NOP, '0);
        send_instr(OP_HALT, '0);
    endtask

    initial begin
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        no_idle = 1'b0;
        vm_count = 0;
        vm_pc = '0;
        vm_halted = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_edge_cases();
        test_full_stack();
        test_random_programs(100);
        test_halt();

        wait_drained();
        repeat (100) @(posedge aclk);
        $display("Ran %0d instructions (edge cases, full stack, random programs, halt),",
                 items_sent);
        $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
